>>> design/lrcm_pkg.sv
// Shared constants, types and the sample encoder of the linear resampler.
package lrcm_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int SAMPLE_BITS     = 24;
    localparam int PHASE_FRAC_BITS = 24;
    localparam int MAX_RESULTS     = 64;
    localparam int CH_W            = 3;
    localparam int POS_W           = 56;
    localparam int CNT_W           = 7;
    localparam int SUM_W           = 27;
    localparam int STEP_W          = 30;

    // Register indexes
    localparam logic [1:0] CFG_SRC_CHANNELS  = 2'd0;
    localparam logic [1:0] CFG_DST_CHANNELS  = 2'd1;
    localparam logic [1:0] CFG_PHASE_STEP    = 2'd2;
    localparam logic [1:0] CFG_OUTPUT_FORMAT = 2'd3;

    // Output formats
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;
    localparam logic [1:0] FMT_F32 = 2'd3;

    localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1) << (PHASE_FRAC_BITS - 2);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << PHASE_FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] source_sample;
        logic                          end_of_track;
    } src_item_t;

    typedef struct packed {
        logic [31:0]                   out_sample_bits;
        logic [CH_W-1:0]               out_channel;
        logic                          frame_done;
        logic signed [SAMPLE_BITS-1:0] mono_level;
        logic                          run_last;
    } dst_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CH_START,
        ST_MUL,
        ST_ADD,
        ST_DIV_VAL,
        ST_ACC,
        ST_DIV_MONO,
        ST_ENC,
        ST_FINISH
    } state_t;

    // Encode a Q1.23 sample; every rounding is half away from zero.
    function automatic logic [31:0] encode_sample(input logic signed [23:0] v,
                                                  input logic [1:0] fmt);
        logic [23:0] x;
        logic [32:0] t8;
        logic [39:0] e16;
        logic [39:0] p16;
        logic [39:0] m16;
        logic [39:0] r16;
        logic [55:0] e32;
        logic [55:0] p32;
        logic [55:0] m32;
        logic [55:0] r32;
        logic [23:0] mf;
        logic [4:0]  msb;
        logic [23:0] sh;
        logic [7:0]  ex;
        logic [31:0] res;
        x   = {~v[23], v[22:0]};
        t8  = ({9'd0, x} << 8) - {9'd0, x} + 33'h0800000;
        e16 = {{16{v[23]}}, v};
        p16 = (e16 << 15) - e16;
        m16 = p16[39] ? (~p16 + 40'd1) : p16;
        r16 = (m16 + 40'h400000) >> 23;
        if (p16[39])
            r16 = ~r16 + 40'd1;
        e32 = {{32{v[23]}}, v};
        p32 = (e32 << 31) - e32;
        m32 = p32[55] ? (~p32 + 56'd1) : p32;
        r32 = (m32 + 56'h400000) >> 23;
        if (p32[55])
            r32 = ~r32 + 56'd1;
        mf  = v[23] ? (~v + 24'd1) : v;
        msb = 5'd0;
        for (int i = 0; i < 24; i++)
            if (mf[i])
                msb = 5'(i);
        sh = mf << (5'd23 - msb);
        ex = 8'd104 + {3'd0, msb};
        case (fmt)
            FMT_U8:  res = {24'd0, t8[31:24]};
            FMT_S16: res = {16'd0, r16[15:0]};
            FMT_S32: res = r32[31:0];
            default: res = (mf == 24'd0) ? 32'd0 : {v[23], ex, sh[22:0]};
        endcase
        return res;
    endfunction

endpackage

>>> design/lrcm_div.sv
// Bit-serial rounding divider: round(num / den), half away from zero.
module lrcm_div
    import lrcm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       num,
    input  logic [3:0]                    den,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] quot
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [SUM_W:0]      dvd_reg, dvd_next;
    logic [SUM_W:0]      quo_reg, quo_next;
    logic [4:0]          rem_reg, rem_next;
    logic [4:0]          dsr_reg, dsr_next;
    logic                neg_reg, neg_next;
    logic [SUM_W-1:0]    mag;
    logic [5:0]          rem_sh;
    logic                take;
    logic [SAMPLE_BITS-1:0] q_mag;

    assign mag    = num[SUM_W-1] ? (~num + SUM_W'(1)) : num;
    assign rem_sh = {rem_reg, dvd_reg[SUM_W]};
    assign take   = (rem_sh >= {1'b0, dsr_reg});

    // Load on start, then take one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(SUM_W);
            dvd_next  = {mag, 1'b0} + {{(SUM_W - 3){1'b0}}, den};
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = {den, 1'b0};
            neg_next  = num[SUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = take ? 5'(rem_sh - {1'b0, dsr_reg}) : rem_sh[4:0];
            dvd_next = dvd_reg << 1;
            quo_next = {quo_reg[SUM_W-1:0], take};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign q_mag = quo_reg[SAMPLE_BITS-1:0];
    assign quot  = neg_reg ? (~q_mag + SAMPLE_BITS'(1)) : q_mag;
    assign done  = done_reg;

endmodule

>>> design/linear_resampler_channel_mapper.sv
// Top level: linear-interpolation resampler with channel mapping and encoding.
//
// Source samples enter interleaved on src_valid/src_ready, one per
// transaction. A sample that does not complete a source frame is taken
// while idle. The sample that completes a frame starts the sequencer, which
// emits every destination frame falling between the previous and current
// source frames on dst_valid/dst_ready, one channel per transaction, then
// the self-interpolated tail when end_of_track is set. src_ready stays low
// until the last result of that transaction has moved to the output register.
// Each destination channel passes through select, multiply, round,
// accumulate and encode steps through one shared multiplier; a mono
// destination repeats multiply and round for each source channel beyond
// the first. The last channel of each destination frame also runs the
// bit-serial divider for the frame mean, as does a many-to-mono average.
// A stalled receiver holds the output register and one pending result; the
// sequencer waits in its encode step until the pending slot frees.
// Reset loads the register defaults (stereo to stereo, unit step, s16) and
// clears both frames and the position counters. The user must write registers
// via cfg_we/cfg_index/cfg_wdata only while idle; the block lacks a check for it.
module linear_resampler_channel_mapper
    import lrcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  src_item_t         src_item,
    output logic              dst_valid,
    input  logic              dst_ready,
    output dst_item_t         dst_item,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [STEP_W-1:0] cfg_wdata
);

    // Configuration
    logic [3:0]        src_channels_reg;
    logic [3:0]        dst_channels_reg;
    logic [STEP_W-1:0] phase_step_reg;
    logic [1:0]        output_format_reg;

    // Stream state
    logic signed [SAMPLE_BITS-1:0] prev_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] cur_reg  [MAX_CHANNELS];
    logic [CH_W-1:0]   chan_pos_reg;
    logic [31:0]       frames_seen_reg;
    logic [POS_W-1:0]  pos_reg;

    // Sequencer
    state_t            state_reg, state_next;
    logic [31:0]       target_reg;
    logic [31:0]       k_reg;
    logic              self_reg;
    logic              eot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CH_W-1:0]   c_reg;
    logic [CH_W-1:0]   kidx_reg;
    logic [48:0]       prod_reg;
    logic              neg_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SUM_W-1:0]       acc_reg;
    logic signed [SUM_W-1:0]       msum_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] mono_reg;
    logic              pend_valid_reg;
    dst_item_t         pend_reg;
    dst_item_t         pend_last;
    logic              dst_valid_reg;
    dst_item_t         dst_item_reg;

    logic [3:0]        sc_n, dc_n;
    logic [CH_W-1:0]   sc_last, dc_last;
    logic [STEP_W-1:0] step;
    logic              mono_mode;
    logic [CH_W-1:0]   src_idx;
    logic signed [SAMPLE_BITS-1:0] sel_a, sel_b;
    logic [SAMPLE_BITS:0] diff, dmag;
    logic [SAMPLE_BITS:0] rnd;
    logic [SAMPLE_BITS+1:0] v_wide;
    logic signed [SAMPLE_BITS-1:0] v_new;
    logic signed [SUM_W-1:0] acc_sum, msum_sum;
    logic              in_fire, frame_complete;
    logic              group_hit;
    logic              out_free, push_ok;
    logic              src_rdy, div_start, push, flush;
    logic signed [SUM_W-1:0] div_num;
    logic [3:0]        div_den;
    logic              div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;
    logic [CNT_W:0]    count_room;

    // Clamp channel counts and step
    assign sc_n = (src_channels_reg == 4'd0) ? 4'd1 :
                  (src_channels_reg > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : src_channels_reg;
    assign dc_n = (dst_channels_reg == 4'd0) ? 4'd1 :
                  (dst_channels_reg > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : dst_channels_reg;
    assign sc_last   = CH_W'(sc_n - 4'd1);
    assign dc_last   = CH_W'(dc_n - 4'd1);
    assign step      = (phase_step_reg < STEP_MIN) ? STEP_MIN : phase_step_reg;
    assign mono_mode = (dc_n == 4'd1) && (sc_n != 4'd1);

    // Map destination channel to source channel
    always_comb
    begin
        if (sc_n == dc_n)
            src_idx = c_reg;
        else if (sc_n == 4'd1)
            src_idx = '0;
        else if (c_reg < sc_last)
            src_idx = c_reg;
        else
            src_idx = sc_last;
    end

    // Interpolation datapath
    assign sel_a  = self_reg ? cur_reg[kidx_reg] : prev_reg[kidx_reg];
    assign sel_b  = cur_reg[kidx_reg];
    assign diff   = {sel_b[SAMPLE_BITS-1], sel_b} - {sel_a[SAMPLE_BITS-1], sel_a};
    assign dmag   = diff[SAMPLE_BITS] ? (~diff + 25'd1) : diff;
    assign rnd    = 25'((prod_reg + 49'h0800000) >> PHASE_FRAC_BITS);
    assign v_wide = neg_reg ? ({{2{a_reg[SAMPLE_BITS-1]}}, a_reg} - {1'b0, rnd})
                            : ({{2{a_reg[SAMPLE_BITS-1]}}, a_reg} + {1'b0, rnd});
    assign v_new    = v_wide[SAMPLE_BITS-1:0];
    assign acc_sum  = acc_reg + SUM_W'(v_new);
    assign msum_sum = msum_reg + SUM_W'(val_reg);

    assign in_fire        = src_valid && src_rdy;
    assign frame_complete = ({1'b0, chan_pos_reg} + 4'd1 >= sc_n) || src_item.end_of_track;
    assign count_room     = {1'b0, count_reg} + {4'd0, dc_n};
    assign group_hit      = (pos_reg[POS_W-1:PHASE_FRAC_BITS] == target_reg)
                            && (count_room <= 8'(MAX_RESULTS));
    assign out_free       = !dst_valid_reg || dst_ready;
    assign push_ok        = !pend_valid_reg || out_free;

    // Mark the pending result as the last one of its transaction
    always_comb
    begin
        pend_last          = pend_reg;
        pend_last.run_last = 1'b1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire && frame_complete)
                begin
                    if (frames_seen_reg != 32'd0 || src_item.end_of_track)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_FINISH;
                end
            ST_CHECK:
                if (group_hit)
                    state_next = ST_CH_START;
                else if (!(eot_reg && !self_reg))
                    state_next = ST_FINISH;
            ST_CH_START: state_next = ST_MUL;
            ST_MUL:      state_next = ST_ADD;
            ST_ADD:
                if (!mono_mode)
                    state_next = ST_ACC;
                else if (kidx_reg == sc_last)
                    state_next = ST_DIV_VAL;
                else
                    state_next = ST_MUL;
            ST_DIV_VAL:
                if (div_done)
                    state_next = ST_ACC;
            ST_ACC:
                state_next = (c_reg == dc_last) ? ST_DIV_MONO : ST_ENC;
            ST_DIV_MONO:
                if (div_done)
                    state_next = ST_ENC;
            ST_ENC:
                if (push_ok)
                    state_next = (c_reg == dc_last) ? ST_CHECK : ST_CH_START;
            ST_FINISH:
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        src_rdy   = 1'b0;
        div_start = 1'b0;
        push      = 1'b0;
        flush     = 1'b0;
        div_num   = msum_sum;
        div_den   = dc_n;
        case (state_reg)
            ST_IDLE: src_rdy = 1'b1;
            ST_ADD:
            begin
                div_num   = acc_sum;
                div_den   = sc_n;
                div_start = mono_mode && (kidx_reg == sc_last);
            end
            ST_ACC:    div_start = (c_reg == dc_last);
            ST_ENC:    push = push_ok;
            ST_FINISH: flush = pend_valid_reg && out_free;
            default:   src_rdy = 1'b0;
        endcase
    end

    lrcm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_channels_reg  <= 4'd2;
            dst_channels_reg  <= 4'd2;
            phase_step_reg    <= STEP_RESET;
            output_format_reg <= FMT_S16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_CHANNELS:  src_channels_reg  <= cfg_wdata[3:0];
                CFG_DST_CHANNELS:  dst_channels_reg  <= cfg_wdata[3:0];
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_wdata;
                CFG_OUTPUT_FORMAT: output_format_reg <= cfg_wdata[1:0];
                default:           src_channels_reg  <= src_channels_reg;
            endcase
        end
    end

    // Frame storage and stream position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
            chan_pos_reg    <= '0;
            frames_seen_reg <= '0;
            pos_reg         <= '0;
        end
        else if (state_reg == ST_IDLE && in_fire)
        begin
            if (chan_pos_reg == '0 && frames_seen_reg != 32'd0)
                for (int i = 0; i < MAX_CHANNELS; i++)
                    prev_reg[i] <= cur_reg[i];
            cur_reg[chan_pos_reg] <= src_item.source_sample;
            if (frame_complete)
            begin
                chan_pos_reg    <= '0;
                frames_seen_reg <= frames_seen_reg + 32'd1;
            end
            else
                chan_pos_reg <= chan_pos_reg + CH_W'(1);
        end
        else if (state_reg == ST_ENC && push_ok && c_reg == dc_last)
            pos_reg <= pos_reg + POS_W'(step);
        else if (state_reg == ST_FINISH && state_next == ST_IDLE && eot_reg)
        begin
            // Drop the track at its end
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
            chan_pos_reg    <= '0;
            frames_seen_reg <= '0;
            pos_reg         <= '0;
        end
    end

    // Sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            dst_valid_reg  <= 1'b0;
            self_reg       <= 1'b0;
            eot_reg        <= 1'b0;
            c_reg          <= '0;
            kidx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // Load the output register from the pending slot, else drop it once taken
            if ((push && pend_valid_reg) || flush)
                dst_valid_reg <= 1'b1;
            else if (dst_ready)
                dst_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (in_fire && frame_complete)
                    begin
                        count_reg <= '0;
                        eot_reg   <= src_item.end_of_track;
                        self_reg  <= (frames_seen_reg == 32'd0);
                    end
                ST_CHECK:
                    if (group_hit)
                        c_reg <= '0;
                    else if (eot_reg && !self_reg)
                        self_reg <= 1'b1;
                ST_CH_START:
                    kidx_reg <= mono_mode ? CH_W'(0) : src_idx;
                ST_ADD:
                    if (mono_mode && kidx_reg != sc_last)
                        kidx_reg <= kidx_reg + CH_W'(1);
                ST_ENC:
                    if (push)
                    begin
                        pend_valid_reg <= 1'b1;
                        count_reg      <= count_reg + CNT_W'(1);
                        if (c_reg != dc_last)
                            c_reg <= c_reg + CH_W'(1);
                    end
                ST_FINISH:
                    if (flush)
                        pend_valid_reg <= 1'b0;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_fire && frame_complete)
                begin
                    k_reg      <= frames_seen_reg;
                    target_reg <= (frames_seen_reg == 32'd0) ? 32'd0
                                                             : frames_seen_reg - 32'd1;
                end
            ST_CHECK:
                if (group_hit)
                    msum_reg <= '0;
                else if (eot_reg && !self_reg)
                    target_reg <= k_reg;
            ST_CH_START:
                acc_reg <= '0;
            ST_MUL:
            begin
                prod_reg <= dmag * pos_reg[PHASE_FRAC_BITS-1:0];
                neg_reg  <= diff[SAMPLE_BITS];
                a_reg    <= sel_a;
            end
            ST_ADD:
                if (mono_mode)
                    acc_reg <= acc_sum;
                else
                    val_reg <= v_new;
            ST_DIV_VAL:
                if (div_done)
                    val_reg <= div_quot;
            ST_ACC:
            begin
                msum_reg <= msum_sum;
                mono_reg <= '0;
            end
            ST_DIV_MONO:
                if (div_done)
                    mono_reg <= div_quot;
            ST_ENC:
                if (push)
                begin
                    if (pend_valid_reg)
                        dst_item_reg <= pend_reg;
                    pend_reg.out_sample_bits <= encode_sample(val_reg, output_format_reg);
                    pend_reg.out_channel     <= c_reg;
                    pend_reg.frame_done      <= (c_reg == dc_last);
                    pend_reg.mono_level      <= mono_reg;
                    pend_reg.run_last        <= 1'b0;
                end
            ST_FINISH:
                if (flush)
                    dst_item_reg <= pend_last;
            default: acc_reg <= acc_reg;
        endcase
    end

    assign src_ready = src_rdy;
    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

    // New input only once every result of the last one has left the pending slot
    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        src_ready |-> !pend_valid_reg)
        else $error("input taken with a result still pending");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count above limit");

    a_mono_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_item.frame_done) |-> (dst_item.mono_level == '0))
        else $error("mono level set off a frame end");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV_VAL || state_reg == ST_DIV_MONO))
        else $error("divider started outside a divide step");

endmodule
